### hdl/sha256h_pkg.sv
// Package for the SHA-256 message hasher: round constants, initial hash
// values, queue entry type and round functions. No dependencies.
package sha256h_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

### hdl/sha256h_if.sv
// Valid/ready channel carrying one payload item.
// Depends on nothing; payload type is a parameter of the interface.
interface sha256h_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/sha256h_queue.sv
// Short FIFO between the byte front end and the compression engine.
// Depends on sha256h_pkg.
module sha256h_queue import sha256h_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  byte_item_t push_data,
  output logic       full,
  input  logic       pop,
  output byte_item_t pop_data,
  output logic       empty
);
  byte_item_t           mem [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr;
  logic [QueueAw-1:0]   rd_ptr;
  logic [QueueAw:0]     count;

  assign full     = (count == (QueueAw + 1)'(QueueDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueueAw + 1)'(push && !full) - (QueueAw + 1)'(pop && !empty);
    end
  end
endmodule

### hdl/sha256h_engine.sv
// Back end: packs bytes into a block, pads, runs 64 rounds per block and
// streams the digest. Depends on sha256h_pkg.
module sha256h_engine import sha256h_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_avail,
  input  byte_item_t   item,
  output logic         item_take,
  output logic         out_valid,
  input  logic         out_ready,
  output digest_item_t out_data
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] hash [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [5:0]  round;
  logic        final_pending;   // padding/length still to go after this block
  logic        len_done;        // this block carries the length
  logic        final_flush;     // a padding block overflowed and still owes the length block
  logic [2:0]  out_idx;
  logic [31:0] wcur;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] wnew;
  logic [31:0] word_in;
  logic [1:0]  lane;

  assign lane = fill[1:0];
  // the message schedule lives in w as a sliding window; w[0] is the current word
  assign wnew = sig1(w[14]) + w[9] + sig0(w[1]) + w[0];
  assign wcur = w[0];
  assign t1   = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[round] + wcur;
  assign t2   = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign item_take = (state == S_IDLE) && item_avail;
  assign out_valid = (state == S_OUT);
  assign out_data  = '{digest_word: hash[out_idx], word_index: out_idx,
                       last_word: (out_idx == 3'd7)};

  // place a byte into the word of the current fill position
  function automatic logic [31:0] put_byte(input logic [31:0] old, input logic [1:0] ln,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = old;
    r[8*(3-ln) +: 8] = b;
    put_byte = r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      bit_length    <= '0;
      round         <= '0;
      final_pending <= 1'b0;
      len_done      <= 1'b0;
      out_idx       <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (item_avail) begin
            if (item.byte_present) begin
              w[fill[5:2]] <= put_byte(w[fill[5:2]], lane, item.message_byte);
              bit_length   <= bit_length + 64'd8;
              fill         <= fill + 6'd1;
              final_pending <= item.end_of_message;
              len_done      <= 1'b0;
              if (fill == 6'd63) begin
                for (int i = 0; i < 8; i++) v[i] <= hash[i];
                round <= '0;
                state <= S_ROUND;
              end else if (item.end_of_message) begin
                state <= S_PAD;
              end
            end else if (item.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          w[fill[5:2]] <= put_byte(w[fill[5:2]], lane, PadByte);
          fill          <= fill + 6'd1;
          final_pending <= 1'b0;
          // pad byte fills the block: compress it, length goes in the next one
          if (fill == 6'd63) begin
            for (int i = 0; i < 8; i++) v[i] <= hash[i];
            round <= '0;
            state <= S_ROUND;
          end else begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          // zero fill one byte per cycle, then length or block flush
          if (fill == 6'd0) begin
            if (len_done) begin
              for (int i = 0; i < 8; i++) v[i] <= hash[i];
              round <= '0;
              state <= S_ROUND;
            end else begin
              w[fill[5:2]] <= put_byte(w[fill[5:2]], lane, 8'h00);
              fill <= fill + 6'd1;
            end
          end else if (fill == LenStart && !len_done) begin
            w[14]    <= bit_length[63:32];
            w[15]    <= bit_length[31:0];
            fill     <= '0;
            len_done <= 1'b1;
            for (int i = 0; i < 8; i++) v[i] <= hash[i];
            round <= '0;
            state <= S_ROUND;
          end else begin
            w[fill[5:2]] <= put_byte(w[fill[5:2]], lane, 8'h00);
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= hash[i];
              round <= '0;
              state <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
          fill <= '0;
          if (len_done) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else if (final_pending) begin
            state <= S_PAD;
          end else if (final_flush) begin
            state <= S_LEN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
              bit_length <= '0;
              len_done   <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a padding block that overflowed past byte 56 still owes the length block
  always_ff @(posedge clk) begin
    if (rst) final_flush <= 1'b0;
    else if ((state == S_LEN || state == S_PAD) && fill == 6'd63 && !len_done)
      final_flush <= 1'b1;
    else if (state == S_ADD) final_flush <= 1'b0;
  end
endmodule

### hdl/sha256h_front.sv
// Front end: registers input items and drops absent non-final bytes.
// Depends on sha256h_pkg.
module sha256h_front import sha256h_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  byte_item_t in_data,
  output logic       in_ready,
  output logic       push,
  output byte_item_t push_data,
  input  logic       full
);
  logic       held;
  byte_item_t held_data;

  assign in_ready  = !held || !full;
  assign push      = held;
  assign push_data = held_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      // drop items that carry nothing
      held <= in_valid && (in_data.byte_present || in_data.end_of_message);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) held_data <= in_data;
  end
endmodule

### hdl/sha256_message_hasher_core.sv
// SHA-256 message hasher: one byte per item in, eight digest words out per
// message. Bytes are taken back to back while the queue has room; every full
// 64-byte block then holds the engine through 64 rounds and the chain add
// in the single round unit, the load coming in the same cycle as the last
// byte. A final item adds padding at one byte per cycle and one or two more
// compressions before the digest words stream.
// Depends on sha256h_pkg and sha256h_if.
module sha256_message_hasher_core import sha256h_pkg::*; (
  input logic clk,
  input logic rst,
  sha256h_if.sink   in_ch,
  sha256h_if.source out_ch
);
  logic       push;
  logic       full;
  logic       empty;
  logic       take;
  byte_item_t push_data;
  byte_item_t pop_data;

  sha256h_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_data(in_ch.data), .in_ready(in_ch.ready),
    .push, .push_data, .full
  );

  sha256h_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop(take), .pop_data, .empty
  );

  sha256h_engine u_engine (
    .clk, .rst, .item_avail(!empty), .item(pop_data), .item_take(take),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

### hdl/sha256h_checker.sv
// Port-level checks for the SHA-256 hasher core; bound to the top level.
// Depends on sha256h_pkg.
module sha256h_checker import sha256h_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input digest_item_t out_data
);
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
  ap_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag wrong");
  ap_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_word |=> out_valid &&
    out_data.word_index == $past(out_data.word_index) + 3'd1) else $error("word order");
endmodule

bind sha256_message_hasher_core sha256h_checker u_checker (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

### tb/sv/sha256_message_hasher_core_checker.sv
// Checker for the SHA-256 message hasher: watches both channels, keeps its own
// SHA-256 state, and compares each digest word. Depends on sha256h_pkg.
`timescale 1ns / 1ps
module sha256_message_hasher_core_checker import sha256h_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  byte_item_t  in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  digest_item_t out_data,
  output int          errors,
  output int          pending
);
  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  hash_st [8];
  logic [7:0]   blk [64];
  int           fill;
  logic [63:0]  msg_bits;
  digest_item_t digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash_st;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic absorb(byte_item_t it);
    digest_item_t d;
    if (it.byte_present) begin
      blk[fill] = it.message_byte;
      msg_bits += 64'd8;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!it.end_of_message) return;
    blk[fill] = PadByte;
    fill++;
    if (fill > 56) begin
      for (int i = fill; i < 64; i++) blk[i] = 8'h00;
      compress();
      fill = 0;
    end
    for (int i = fill; i < 56; i++) blk[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk[63-i] = msg_bits[8*i +: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_st[i];
      d.word_index  = 3'(i);
      d.last_word   = (i == 7);
      digest_q.push_back(d);
    end
    hash_st = HInit;
    fill = 0;
    msg_bits = '0;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    hash_st = HInit;
    fill = 0;
    msg_bits = '0;
  end

  always @(posedge clk) begin
    digest_item_t exp_d;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected digest item %h idx %0d last %0b", $time,
                   out_data.digest_word, out_data.word_index, out_data.last_word);
        end else begin
          exp_d = digest_q.pop_front();
          if (exp_d.digest_word !== out_data.digest_word) begin
            errors++;
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_d.digest_word, out_data.digest_word);
          end
          if (exp_d.word_index !== out_data.word_index) begin
            errors++;
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_d.word_index, out_data.word_index);
          end
          if (exp_d.last_word !== out_data.last_word) begin
            errors++;
            $display("%0t: last_word expected %0b actual %0b", $time,
                     exp_d.last_word, out_data.last_word);
          end
        end
      end
      if (in_valid && in_ready) absorb(in_data);
    end
    pending = digest_q.size();
  end
endmodule

### tb/sv/sha256_message_hasher_core_tb.sv
// Top of the SHA-256 hasher testbench: clock, reset, message stimulus and
// verdict. Depends on sha256h_pkg, sha256h_if, the checker and the core.
`timescale 1ns / 1ps
module sha256_message_hasher_core_tb import sha256h_pkg::*;;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  bit   sent_all = 1'b0;

  sha256h_if #(.payload_t(byte_item_t))   in_ch  (.clk(clk));
  sha256h_if #(.payload_t(digest_item_t)) out_ch (.clk(clk));

  sha256_message_hasher_core u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sha256_message_hasher_core_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  // Send one item, with a random idle gap first unless a burst is running.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(logic [7:0] b, logic present, logic last, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{message_byte: b, byte_present: present, end_of_message: last};
    // ready only moves at rising edges, so it is stable here
    while (!in_ch.ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit absent_end, bit burst);
    for (int i = 0; i < len; i++) begin
      if (!burst && $urandom_range(0, 19) == 0)
        send_byte(8'($urandom), 1'b0, 1'b0, burst);  // ignored filler
      send_byte(8'($urandom), 1'b1, (i == len - 1) && !absent_end, burst);
    end
    if (absent_end || len == 0) send_byte(8'($urandom), 1'b0, 1'b1, burst);
  endtask

  // Receiver stall: draw a wait per item, sometimes run without stalls.
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      while (!out_ch.valid) @(negedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int total;
    int len;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed: empty message, absent-end forms, padding edges at 55/56/64.
    send_message(0, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1, 1'b0);
    send_byte(8'hab, 1'b1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1, 1'b0);
    send_message(3, 1'b0, 1'b1);
    send_message(55, 1'b0, 1'b1);
    send_message(56, 1'b0, 1'b0);
    send_message(64, 1'b1, 1'b1);
    send_message(64, 1'b0, 1'b0);
    total = 0;
    while (total < 210) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(50, 70);
        default: len = $urandom_range(1, 40);
      endcase
      send_message(len, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      total += len + 1;
    end
    in_ch.valid <= 1'b0;
    sent_all = 1'b1;
  end

  initial begin
    @(posedge sent_all);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("sha256_message_hasher_core_tb: done, clean");
    else
      $display("sha256_message_hasher_core_tb: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("sha256_message_hasher_core_tb: done, errors");
    $finish;
  end
endmodule
